FILE: design/sac_pkg.sv
`default_nettype none

package sac_pkg;

    // one access word on the request channel
    typedef struct packed {
        logic        kind;
        logic [15:0] byte_addr;
        logic [31:0] wdata;
        logic [31:0] wmask;
        logic [7:0]  victim_pick;
    } sac_req_t;

    // one result word on the response channel
    typedef struct packed {
        logic [31:0] rdata;
        logic        hit;
        logic [1:0]  way_used;
        logic        evicted_valid;
    } sac_rsp_t;

    // access kinds
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

endpackage

`default_nettype wire

FILE: design/set_assoc_write_through_cache_core.sv
// Set-associative write-allocate write-through cache with its backing word
// memory inside the block.
// Request channel: req_valid / req_stall / req carry one access word (read or
// masked write). Response channel: rsp_valid / rsp_stall / rsp carry exactly
// one result word per access, in access order.
// One access is in flight at a time. On its way from acceptance to the
// result register a hit passes tag compare and data read, then merge and
// result load. A new access is accepted only after the previous one has
// loaded its result. A miss adds a line fill from backing memory, word by
// word through the single backing memory port.
// The result sits in an output register; the next access is accepted while
// it waits, and the block only holds in its merge step while rsp_stall keeps
// a previous result from being taken.
// After reset all lines are invalid and a clearing pass zeroes the backing
// memory, one word per cycle over 2^(ADDR_BITS-2) words (16384 at default),
// with req_stall high throughout.
`default_nettype none

module set_assoc_write_through_cache_core
    import sac_pkg::*;
#(
    parameter int BLOCK_BITS = 6,
    parameter int TOTAL_BITS = 14,
    parameter int WAY_BITS   = 2,
    parameter int ADDR_BITS  = 16
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire sac_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output sac_rsp_t      rsp
);

    localparam int MEM_AW   = ADDR_BITS - 2;
    localparam int LW_BITS  = BLOCK_BITS - 2;
    localparam int LW       = 1 << LW_BITS;
    localparam int SET_BITS = (TOTAL_BITS > BLOCK_BITS + WAY_BITS) ?
                              (TOTAL_BITS - BLOCK_BITS - WAY_BITS) : 0;
    localparam int SET_IW   = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int SETS     = 1 << SET_BITS;
    localparam int BLK_W    = ADDR_BITS - BLOCK_BITS;
    localparam int TAG_RAW  = BLK_W - SET_BITS;
    localparam int TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int WAY_IW   = (WAY_BITS > 0) ? WAY_BITS : 1;
    localparam int WAYS     = 1 << WAY_BITS;
    localparam int LINE_W   = SET_IW + WAY_IW;
    localparam int DATA_AW  = LINE_W + LW_BITS;
    localparam logic [SET_IW-1:0] SET_MASK = SET_IW'(SETS - 1);
    localparam logic [WAY_IW-1:0] WAY_MASK = WAY_IW'(WAYS - 1);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_LOOKUP = 3'd2;
    localparam logic [2:0] S_FILL   = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;
    localparam logic [2:0] S_RESP   = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [MEM_AW-1:0]    clr_reg, clr_next;
    logic [LW_BITS:0]     cnt_reg, cnt_next;
    sac_req_t             req_reg;
    logic [WAY_IW-1:0]    way_reg, way_next;
    logic                 hit_reg, hit_next;
    logic                 evict_reg, evict_next;
    logic [2**LINE_W-1:0] valid_reg, valid_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    sac_rsp_t             rsp_reg, rsp_next;

    // address decode of the incoming word and of the held word
    logic [ADDR_BITS-1:0] addr_in, addr;
    logic [BLK_W-1:0]     blk_in, blk;
    logic [SET_IW-1:0]    set_in, set_idx;
    logic [TAG_W-1:0]     tag;
    logic [LW_BITS-1:0]   word;
    logic [LINE_W-1:0]    line;

    assign addr_in = ADDR_BITS'(req.byte_addr);
    assign blk_in  = addr_in[ADDR_BITS-1:BLOCK_BITS];
    assign set_in  = SET_IW'(blk_in) & SET_MASK;
    assign addr    = ADDR_BITS'(req_reg.byte_addr);
    assign blk     = addr[ADDR_BITS-1:BLOCK_BITS];
    assign set_idx = SET_IW'(blk) & SET_MASK;
    assign tag     = TAG_W'(blk >> SET_BITS);
    assign word    = addr[BLOCK_BITS-1:2];
    assign line    = {set_idx, way_reg & WAY_MASK};

    // memories: tag rows per set, line words, backing memory
    logic                   tag_we, tag_re;
    logic [SET_IW-1:0]      tag_addr;
    logic [WAYS*TAG_W-1:0]  tag_row_q, tag_row_new;
    logic                   dat_we, dat_re;
    logic [DATA_AW-1:0]     dat_addr;
    logic [31:0]            dat_wdata, dat_q;
    logic                   mem_we, mem_re;
    logic [MEM_AW-1:0]      mem_addr;
    logic [31:0]            mem_wdata, mem_q;

    sac_ram #(.AW(SET_IW), .DW(WAYS*TAG_W)) u_tag (
        .clk   (clk),
        .we    (tag_we),
        .re    (tag_re),
        .addr  (tag_addr),
        .wdata (tag_row_new),
        .q     (tag_row_q)
    );

    sac_ram #(.AW(DATA_AW), .DW(32)) u_data (
        .clk   (clk),
        .we    (dat_we),
        .re    (dat_re),
        .addr  (dat_addr),
        .wdata (dat_wdata),
        .q     (dat_q)
    );

    sac_ram #(.AW(MEM_AW), .DW(32)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .q     (mem_q)
    );

    // tag compare, first free way and victim
    logic              hit_any, free_any;
    logic [WAY_IW-1:0] hit_way, free_way, lk_way;

    always_comb
    begin
        hit_any  = 1'b0;
        free_any = 1'b0;
        hit_way  = '0;
        free_way = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (valid_reg[{set_idx, WAY_IW'(i)}] &&
                tag_row_q[i*TAG_W +: TAG_W] == tag)
            begin
                hit_any = 1'b1;
                hit_way = WAY_IW'(i);
            end
            if (!valid_reg[{set_idx, WAY_IW'(i)}])
            begin
                free_any = 1'b1;
                free_way = WAY_IW'(i);
            end
        end
        if (hit_any)
        begin
            lk_way = hit_way;
        end
        else if (free_any)
        begin
            lk_way = free_way;
        end
        else
        begin
            lk_way = WAY_IW'(req_reg.victim_pick) & WAY_MASK;
        end
    end

    // new tag row with the filled way replaced
    always_comb
    begin
        tag_row_new = tag_row_q;
        tag_row_new[(lk_way & WAY_MASK)*TAG_W +: TAG_W] = tag;
    end

    // merged word and response commit
    logic [31:0] merged;
    logic        commit;

    assign merged = (req_reg.kind == KIND_WRITE) ?
                    ((dat_q & ~req_reg.wmask) | (req_reg.wdata & req_reg.wmask)) : dat_q;
    assign commit = (state_reg == S_RESP) && (!rsp_valid_reg || !rsp_stall);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cnt_next       = cnt_reg;
        way_next       = way_reg;
        hit_next       = hit_reg;
        evict_next     = evict_reg;
        valid_next     = valid_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        tag_we         = 1'b0;
        tag_re         = 1'b0;
        tag_addr       = set_idx;
        dat_we         = 1'b0;
        dat_re         = 1'b0;
        dat_addr       = {line, word};
        dat_wdata      = merged;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = addr[ADDR_BITS-1:2];
        mem_wdata      = merged;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                tag_addr = set_in;
                if (req_valid)
                begin
                    tag_re     = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                way_next   = lk_way;
                hit_next   = hit_any;
                evict_next = !hit_any && !free_any;
                if (hit_any)
                begin
                    dat_re     = 1'b1;
                    dat_addr   = {set_idx, lk_way & WAY_MASK, word};
                    state_next = S_RESP;
                end
                else
                begin
                    tag_we     = 1'b1;
                    valid_next[{set_idx, lk_way & WAY_MASK}] = 1'b1;
                    cnt_next   = '0;
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                // read backing word cnt, write line word cnt-1
                if (cnt_reg != (LW_BITS + 1)'(LW))
                begin
                    mem_re   = 1'b1;
                    mem_addr = {blk, cnt_reg[LW_BITS-1:0]};
                end
                if (cnt_reg != '0)
                begin
                    dat_we    = 1'b1;
                    dat_addr  = {line, LW_BITS'(cnt_reg - 1'b1)};
                    dat_wdata = mem_q;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (LW_BITS + 1)'(LW))
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                dat_re     = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (commit)
                begin
                    if (req_reg.kind == KIND_WRITE)
                    begin
                        dat_we = 1'b1;
                        mem_we = 1'b1;
                    end
                    rsp_valid_next         = 1'b1;
                    rsp_next.rdata         = merged;
                    rsp_next.hit           = hit_reg;
                    rsp_next.way_used      = 2'(way_reg);
                    rsp_next.evicted_valid = evict_reg;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            valid_reg     <= valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req_valid)
        begin
            req_reg <= req;
        end
        way_reg   <= way_next;
        hit_reg   <= hit_next;
        evict_reg <= evict_next;
        rsp_reg   <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

FILE: design/sac_ram.sv
`default_nettype none

module sac_ram #(
    parameter int AW = 8,
    parameter int DW = 32
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic          re,
    input  wire logic [AW-1:0] addr,
    input  wire logic [DW-1:0] wdata,
    output logic      [DW-1:0] q
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] q_reg;

    // single port, registered read data held until the next read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            q_reg <= mem[addr];
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire
